FILE: hdl/stq_pkg.sv
// Shared types and constants for the sorted turn priority queue.
// No dependencies; every other file imports this package.
package stq_pkg;

    // Queue geometry and field widths
    localparam int QUEUE_DEPTH = 8;
    localparam int ID_BITS     = 16;
    localparam int SPEED_BITS  = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // Actions carried by an input beat
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_POP    = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_ROUND  = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_FIND   = 3'd5
    } action_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_SKIPPED   = 3'd4
    } status_t;

    // Per-cell command, broadcast along the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP_INSERT,
        CELL_POP,
        CELL_REMOVE,
        CELL_CLEAR
    } cell_op_t;

    // One queued entry
    typedef struct packed {
        logic [ID_BITS-1:0]           id;
        logic signed [SPEED_BITS-1:0] speed;
        logic                         team;
    } slot_t;

    // Entry with occupancy flag, handed towards the head
    typedef struct packed {
        logic  valid;
        slot_t slot;
    } vslot_t;

    // Link handed towards the tail: the cell's view, its insert flag, match seen
    typedef struct packed {
        vslot_t base;
        logic   after;
        logic   seen;
    } fwd_t;

    // Input beat
    typedef struct packed {
        logic [2:0]                   action;
        logic [ID_BITS-1:0]           entry_id;
        logic signed [SPEED_BITS-1:0] entry_speed;
        logic                         entry_team;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [2:0]                   status;
        logic [ID_BITS-1:0]           taken_id;
        logic signed [SPEED_BITS-1:0] taken_speed;
        logic                         taken_team;
        logic                         top_valid;
        logic [ID_BITS-1:0]           top_id;
        logic signed [SPEED_BITS-1:0] top_speed;
        logic [CNT_BITS-1:0]          ours_count;
        logic [CNT_BITS-1:0]          enemy_count;
    } out_t;

endpackage

FILE: hdl/stq_cell.sv
// One queue cell: holds a single entry and its valid flag, compares against
// the broadcast key and takes data from either neighbour. Uses stq_pkg.
module stq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  stq_pkg::cell_op_t cmd,
    input  stq_pkg::slot_t    new_slot,
    input  logic [stq_pkg::ID_BITS-1:0] key_id,
    input  stq_pkg::fwd_t     prev_fwd,
    input  stq_pkg::vslot_t   next_cell,
    output stq_pkg::fwd_t     fwd,
    output stq_pkg::vslot_t   cur,
    output stq_pkg::vslot_t   cur_next,
    output logic              first_hit
);
    import stq_pkg::*;

    slot_t  slot_reg;
    logic   valid_reg;
    vslot_t own;
    vslot_t base;
    vslot_t state_next;
    logic   match;

    assign own.valid = valid_reg;
    assign own.slot  = slot_reg;
    assign cur       = own;

    // View of this position once the head has been popped (round over)
    assign base = (cmd == CELL_POP_INSERT) ? next_cell : own;

    // Insert lands at or before this cell (towards the head) when the view is empty or slower
    assign fwd.base  = base;
    assign fwd.after = !base.valid || (base.slot.speed < new_slot.speed);

    // Id match and the running "seen a match" flag towards the tail
    assign match     = valid_reg && (slot_reg.id == key_id);
    assign fwd.seen  = prev_fwd.seen || match;
    assign first_hit = match && !prev_fwd.seen;

    // Select the next contents
    always_comb begin
        state_next = own;
        unique case (cmd)
            CELL_INSERT, CELL_POP_INSERT: begin
                if (fwd.after && !prev_fwd.after) begin
                    state_next.valid = 1'b1;
                    state_next.slot  = new_slot;
                end else if (fwd.after) begin
                    state_next = prev_fwd.base;
                end else begin
                    state_next = base;
                end
            end
            CELL_POP:    state_next = next_cell;
            CELL_REMOVE: begin
                if (fwd.seen) begin
                    state_next = next_cell;
                end
            end
            CELL_CLEAR:  state_next.valid = 1'b0;
            CELL_HOLD:   state_next = own;
            default:     state_next = own;
        endcase
    end

    assign cur_next = state_next;

    // Occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= state_next.valid;
        end
    end

    // Entry payload
    always_ff @(posedge aclk) begin
        slot_reg <= state_next.slot;
    end

endmodule

FILE: hdl/stq_row.sv
// Row of queue cells, head at cell 0; links neighbours and gathers the
// first id match and the head entry. Uses stq_pkg and stq_cell.
module stq_row #(
    parameter int DEPTH = stq_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  stq_pkg::cell_op_t cmd,
    input  stq_pkg::slot_t    new_slot,
    input  logic [stq_pkg::ID_BITS-1:0] key_id,
    output stq_pkg::vslot_t   head,
    output stq_pkg::vslot_t   head_next,
    output logic              found,
    output stq_pkg::slot_t    found_slot
);
    import stq_pkg::*;

    fwd_t   fwd_link [DEPTH+1];
    vslot_t cells    [DEPTH+1];
    vslot_t cells_next [DEPTH];
    logic   first    [DEPTH];

    // Ends of the chain: nothing before the head, an empty cell past the tail
    assign fwd_link[0] = '0;
    assign cells[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        stq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .new_slot  (new_slot),
            .key_id    (key_id),
            .prev_fwd  (fwd_link[i]),
            .next_cell (cells[i+1]),
            .fwd       (fwd_link[i+1]),
            .cur       (cells[i]),
            .cur_next  (cells_next[i]),
            .first_hit (first[i])
        );
    end

    assign head      = cells[0];
    assign head_next = cells_next[0];
    assign found     = fwd_link[DEPTH].seen;

    // Gather the first matching entry
    always_comb begin
        found_slot = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                found_slot = found_slot | cells[i].slot;
            end
        end
    end

endmodule

FILE: hdl/sorted_turn_priority_queue_top.sv
// Sorted turn priority queue, top level: handshake, action decode, team counts.
// The result beat is registered: valid in the cycle after the input beat is accepted.
// Throughput: one action per cycle unless m_ready stalls; every cell compares and shifts.
// Reset (aresetn low, synchronous) clears cell valid flags, counts and the
// output valid flag; entry payloads and the result data are not cleared.
module sorted_turn_priority_queue_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  stq_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output stq_pkg::out_t m_data
);
    import stq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;

    logic                        m_valid_reg;
    out_t                        m_data_reg;
    out_t                        m_data_next;
    logic [CNT_BITS-1:0]         ours_reg,  ours_next;
    logic [CNT_BITS-1:0]         enemy_reg, enemy_next;
    logic [CNT_BITS-1:0]         occupied;
    logic                        accept;
    action_t                     action;
    status_t                     status;
    cell_op_t                    cmd;
    cell_op_t                    row_cmd;
    slot_t                       new_slot;
    slot_t                       taken;
    slot_t                       dec_slot;
    logic                        have_taken;
    vslot_t                      head;
    vslot_t                      head_next;
    logic                        found;
    slot_t                       found_slot;
    logic signed [SPEED_BITS-1:0] speed_min;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign occupied = ours_reg + enemy_reg;
    assign action   = action_t'(s_data.action);

    // Hold the row unless a beat is taken in this cycle
    assign row_cmd = accept ? cmd : CELL_HOLD;

    // Head with its speed lowered by one, held at the minimum
    assign speed_min = {1'b1, {(SPEED_BITS-1){1'b0}}};
    always_comb begin
        dec_slot = head.slot;
        if (head.slot.speed != speed_min) begin
            dec_slot.speed = head.slot.speed - SPEED_BITS'(1);
        end
    end

    stq_row #(
        .DEPTH (DEPTH)
    ) u_row (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (row_cmd),
        .new_slot   (new_slot),
        .key_id     (s_data.entry_id),
        .head       (head),
        .head_next  (head_next),
        .found      (found),
        .found_slot (found_slot)
    );

    // Decode the action into a row command, status and count update
    always_comb begin
        cmd        = CELL_HOLD;
        status     = ST_OK;
        have_taken = 1'b0;
        taken      = '0;
        ours_next  = ours_reg;
        enemy_next = enemy_reg;
        new_slot.id    = s_data.entry_id;
        new_slot.speed = s_data.entry_speed;
        new_slot.team  = s_data.entry_team;
        unique case (action)
            ACT_INSERT: begin
                if (occupied == CNT_BITS'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    cmd = CELL_INSERT;
                    if (s_data.entry_team) begin
                        enemy_next = enemy_reg + CNT_BITS'(1);
                    end else begin
                        ours_next = ours_reg + CNT_BITS'(1);
                    end
                end
            end
            ACT_POP, ACT_REMOVE: begin
                if (occupied == '0) begin
                    status = ST_EMPTY;
                end else if (action == ACT_REMOVE && !found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    cmd        = (action == ACT_POP) ? CELL_POP : CELL_REMOVE;
                    taken      = (action == ACT_POP) ? head.slot : found_slot;
                    have_taken = 1'b1;
                    if (taken.team) begin
                        enemy_next = enemy_reg - CNT_BITS'(1);
                    end else begin
                        ours_next = ours_reg - CNT_BITS'(1);
                    end
                end
            end
            ACT_ROUND: begin
                if (ours_reg == '0 || enemy_reg == '0) begin
                    status = ST_SKIPPED;
                end else begin
                    cmd        = CELL_POP_INSERT;
                    new_slot   = dec_slot;
                    taken      = dec_slot;
                    have_taken = 1'b1;
                end
            end
            ACT_CLEAR: begin
                cmd        = CELL_CLEAR;
                ours_next  = '0;
                enemy_next = '0;
            end
            ACT_FIND: begin
                if (occupied == '0) begin
                    status = ST_EMPTY;
                end else if (!found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    taken      = found_slot;
                    have_taken = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Assemble the result beat
    always_comb begin
        m_data_next             = '0;
        m_data_next.status      = status;
        m_data_next.ours_count  = ours_next;
        m_data_next.enemy_count = enemy_next;
        if (have_taken) begin
            m_data_next.taken_id    = taken.id;
            m_data_next.taken_speed = taken.speed;
            m_data_next.taken_team  = taken.team;
        end
        if (head_next.valid) begin
            m_data_next.top_valid = 1'b1;
            m_data_next.top_id    = head_next.slot.id;
            m_data_next.top_speed = head_next.slot.speed;
        end
    end

    // Team counts and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ours_reg    <= '0;
            enemy_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                ours_reg  <= ours_next;
                enemy_reg <= enemy_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

FILE: test/tb_top.sv
// Testbench for sorted_turn_priority_queue_top: directed and random actions on the queue.
// Needs stq_pkg and the top level; a built-in queue predictor checks every result beat.
`timescale 1ns / 100ps

module tb_top;
    import stq_pkg::*;

    // Action codes the block leaves unused
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam logic signed [SPEED_BITS-1:0] SPEED_MIN = {1'b1, {(SPEED_BITS-1){1'b0}}};
    localparam logic signed [SPEED_BITS-1:0] SPEED_MAX = {1'b0, {(SPEED_BITS-1){1'b1}}};
    localparam int RANDOM_PER_PHASE = 406;
    localparam int CYCLE_LIMIT      = 250000;
    localparam logic TEAM_OURS  = 1'b0;
    localparam logic TEAM_ENEMY = 1'b1;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    // Predicted queue contents, in service order from the head
    slot_t turn_line [QUEUE_DEPTH];
    int    ours_held;
    int    enemy_held;
    out_t  pending_results [$];

    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    sorted_turn_priority_queue_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // Hold off the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic int queue_fill();
        return ours_held + enemy_held;
    endfunction

    function automatic in_t make_beat(input logic [2:0] action, input logic [ID_BITS-1:0] id,
                                      input logic signed [SPEED_BITS-1:0] speed,
                                      input logic team);
        in_t beat;
        beat.action      = action;
        beat.entry_id    = id;
        beat.entry_speed = speed;
        beat.entry_team  = team;
        return beat;
    endfunction

    // Place an entry behind every entry of equal or greater speed
    task automatic place_sorted(input slot_t entry);
        int fill;
        int spot;
        fill = queue_fill();
        spot = fill;
        for (int i = 0; i < fill; i++) begin
            if ($signed(turn_line[i].speed) < $signed(entry.speed)) begin
                spot = i;
                break;
            end
        end
        for (int i = fill; i > spot; i--) turn_line[i] = turn_line[i-1];
        turn_line[spot] = entry;
        if (entry.team) enemy_held++; else ours_held++;
    endtask

    // Take the entry at a position out, closing the gap behind it
    task automatic take_out(input int spot, output slot_t entry);
        int fill;
        fill = queue_fill();
        entry = turn_line[spot];
        for (int i = spot; i + 1 < fill; i++) turn_line[i] = turn_line[i+1];
        if (entry.team) begin
            if (enemy_held > 0) enemy_held--;
        end else begin
            if (ours_held > 0) ours_held--;
        end
    endtask

    function automatic int locate_id(input logic [ID_BITS-1:0] id);
        for (int i = 0; i < queue_fill(); i++) begin
            if (turn_line[i].id == id) return i;
        end
        return -1;
    endfunction

    // Advance the queue model by one action and queue the result it should give
    task automatic apply_action(input in_t beat);
        out_t  res;
        slot_t entry;
        int    spot;
        logic  have_taken;
        res        = '0;
        entry      = '0;
        have_taken = 1'b0;
        res.status = ST_OK;
        case (beat.action)
            ACT_INSERT: begin
                if (queue_fill() >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    entry.id    = beat.entry_id;
                    entry.speed = beat.entry_speed;
                    entry.team  = beat.entry_team;
                    place_sorted(entry);
                    entry = '0;
                end
            end
            ACT_POP: begin
                if (queue_fill() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    take_out(0, entry);
                    have_taken = 1'b1;
                end
            end
            ACT_REMOVE, ACT_FIND: begin
                spot = locate_id(beat.entry_id);
                if (queue_fill() == 0) begin
                    res.status = ST_EMPTY;
                end else if (spot < 0) begin
                    res.status = ST_NOT_FOUND;
                end else if (beat.action == ACT_REMOVE) begin
                    take_out(spot, entry);
                    have_taken = 1'b1;
                end else begin
                    entry      = turn_line[spot];
                    have_taken = 1'b1;
                end
            end
            ACT_ROUND: begin
                if (ours_held == 0 || enemy_held == 0) begin
                    res.status = ST_SKIPPED;
                end else begin
                    take_out(0, entry);
                    if (entry.speed != SPEED_MIN) entry.speed = entry.speed - 1'b1;
                    place_sorted(entry);
                    have_taken = 1'b1;
                end
            end
            ACT_CLEAR: begin
                ours_held  = 0;
                enemy_held = 0;
            end
            default: begin
            end
        endcase
        if (have_taken) begin
            res.taken_id    = entry.id;
            res.taken_speed = entry.speed;
            res.taken_team  = entry.team;
        end
        if (queue_fill() > 0) begin
            res.top_valid = 1'b1;
            res.top_id    = turn_line[0].id;
            res.top_speed = turn_line[0].speed;
        end
        res.ours_count  = CNT_BITS'(ours_held);
        res.enemy_count = CNT_BITS'(enemy_held);
        pending_results = {pending_results, res};
    endtask

    // Present one beat, idling first at random, and hold it until taken
    task automatic send_beat(input in_t beat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_action(beat);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Compare every result beat with the oldest prediction
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", m_data));
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(m_data.status), 32'(want.status));
                check_field("taken_id", 32'(m_data.taken_id), 32'(want.taken_id));
                check_field("taken_speed", 32'(m_data.taken_speed), 32'(want.taken_speed));
                check_field("taken_team", 32'(m_data.taken_team), 32'(want.taken_team));
                check_field("top_valid", 32'(m_data.top_valid), 32'(want.top_valid));
                check_field("top_id", 32'(m_data.top_id), 32'(want.top_id));
                check_field("top_speed", 32'(m_data.top_speed), 32'(want.top_speed));
                check_field("ours_count", 32'(m_data.ours_count), 32'(want.ours_count));
                check_field("enemy_count", 32'(m_data.enemy_count), 32'(want.enemy_count));
            end
        end
    end

    // Every action that needs entries on an empty queue
    task automatic test_empty_queue();
        send_beat(make_beat(ACT_POP, 16'd5, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_REMOVE, 16'd5, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_FIND, 16'd5, 16'sd0, TEAM_ENEMY));
        send_beat(make_beat(ACT_ROUND, 16'd0, 16'sd0, TEAM_OURS));
    endtask

    // Fill with extreme fields, ties and a duplicate id, then overfill
    task automatic test_fill_and_full();
        send_beat(make_beat(ACT_INSERT, 16'hFFFF, SPEED_MAX, TEAM_ENEMY));
        send_beat(make_beat(ACT_INSERT, 16'h0000, SPEED_MIN, TEAM_OURS));
        send_beat(make_beat(ACT_INSERT, 16'h00A5, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_INSERT, 16'h5A5A, 16'sd0, TEAM_ENEMY));
        send_beat(make_beat(ACT_INSERT, 16'd7, 16'sd100, TEAM_OURS));
        send_beat(make_beat(ACT_INSERT, 16'd7, -16'sd1, TEAM_ENEMY));
        send_beat(make_beat(ACT_INSERT, 16'd3, SPEED_MAX, TEAM_OURS));
        send_beat(make_beat(ACT_INSERT, 16'd9, SPEED_MIN, TEAM_ENEMY));
        send_beat(make_beat(ACT_INSERT, 16'h1234, 16'sd5, TEAM_OURS));
    endtask

    // First match wins on duplicate ids; a missing id is reported
    task automatic test_remove_find();
        send_beat(make_beat(ACT_FIND, 16'd7, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_REMOVE, 16'd7, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_FIND, 16'd7, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_REMOVE, 16'hBEEF, 16'sd0, TEAM_OURS));
    endtask

    // Round over: normal, saturating at the minimum speed, and skipped for one team
    task automatic test_round_over();
        send_beat(make_beat(ACT_ROUND, 16'd0, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_CLEAR, 16'h8001, -16'sd2, TEAM_ENEMY));
        send_beat(make_beat(ACT_INSERT, 16'd1, SPEED_MIN, TEAM_OURS));
        send_beat(make_beat(ACT_INSERT, 16'd2, SPEED_MIN, TEAM_ENEMY));
        send_beat(make_beat(ACT_ROUND, 16'd0, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_POP, 16'd0, 16'sd0, TEAM_OURS));
        send_beat(make_beat(ACT_ROUND, 16'd0, 16'sd0, TEAM_OURS));
    endtask

    task automatic test_spare_codes();
        send_beat(make_beat(ACT_SPARE_LO, 16'h3C3C, 16'sd77, TEAM_ENEMY));
        send_beat(make_beat(ACT_SPARE_HI, 16'hC3C3, -16'sd77, TEAM_OURS));
    endtask

    // Speeds cluster to force ties, with extremes and full-range values mixed in
    function automatic logic signed [SPEED_BITS-1:0] random_speed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return SPEED_BITS'($signed($urandom_range(0, 6)) - 3);
        if (pick < 50) return SPEED_MIN + SPEED_BITS'($urandom_range(0, 2));
        if (pick < 55) return SPEED_MAX;
        return SPEED_BITS'($urandom);
    endfunction

    // Ids mostly hit live entries or a small pool, so removes and finds succeed
    function automatic logic [ID_BITS-1:0] random_id();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45 && queue_fill() > 0) return turn_line[$urandom_range(0, queue_fill() - 1)].id;
        if (pick < 80) return ID_BITS'($urandom_range(0, 15));
        return ID_BITS'($urandom);
    endfunction

    function automatic logic [2:0] random_action();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38) return ACT_INSERT;
        if (pick < 50) return ACT_POP;
        if (pick < 63) return ACT_REMOVE;
        if (pick < 80) return ACT_ROUND;
        if (pick < 92) return ACT_FIND;
        if (pick < 96) return ACT_CLEAR;
        return ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
    endfunction

    // Random traffic under one idling setting; unused codes do not count
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int   sent;
        in_t  beat;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < RANDOM_PER_PHASE) begin
            beat = make_beat(random_action(), random_id(), random_speed(),
                             logic'($urandom_range(0, 1)));
            send_beat(beat);
            if (beat.action != ACT_SPARE_LO && beat.action != ACT_SPARE_HI) sent++;
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        ours_held  = 0;
        enemy_held = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_fill_and_full();
        test_remove_find();
        test_round_over();
        test_spare_codes();
        test_random_traffic(0, 0);
        test_random_traffic(63, 0);
        test_random_traffic(0, 63);
        test_random_traffic(8, 8);

        // Drain, then allow for the registered result path
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
